FILE: design/fpea_pkg.sv
`timescale 1ns / 1ps

package fpea_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam int PAGE_W  = 32;
    localparam int COUNT_W = 16;

    localparam logic [PAGE_W-1:0] END_PAGE_RESET = 32'd1;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [1:0] {
        SRC_EXACT = 2'd0,
        SRC_SPLIT = 2'd1,
        SRC_FRESH = 2'd2,
        SRC_FREE  = 2'd3
    } source_t;

    typedef struct packed {
        logic load;
        logic compare;
        logic select;
        logic update;
    } dp_cmd_t;

endpackage

FILE: design/fpea_ctrl.sv
`timescale 1ns / 1ps

module fpea_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    output fpea_pkg::dp_cmd_t cmd
);
    import fpea_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CMP  = 4'b0010,
        S_SEL  = 4'b0100,
        S_UPD  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = S_SEL;
            end
            S_SEL:
            begin
                cmd.select = 1'b1;
                state_next = S_UPD;
            end
            S_UPD:
            begin
                cmd.update = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != S_IDLE);

`ifndef SYNTHESIS
    // every accepted transaction reaches the table update after the compare and select states
    a_accept_to_update: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 cmd.update)
        else $error("accepted transaction did not reach update");
`endif

endmodule

FILE: design/fpea_dp.sv
`timescale 1ns / 1ps

module fpea_dp
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  fpea_pkg::dp_cmd_t               cmd,
    input  logic                            action,
    input  logic [fpea_pkg::PAGE_W-1:0]     free_page,
    input  logic [fpea_pkg::COUNT_W-1:0]    page_count,
    input  logic                            cfg_we,
    input  logic [fpea_pkg::PAGE_W-1:0]     cfg_data,
    output logic                            res_valid,
    output logic [fpea_pkg::PAGE_W-1:0]     res_page,
    output fpea_pkg::source_t               res_source,
    output logic                            res_dropped
);
    import fpea_pkg::*;

    // free table, ordered by arrival; entries at and above entry_count are stale
    logic [PAGE_W-1:0]  tbl_start_reg [TABLE_DEPTH];
    logic [COUNT_W-1:0] tbl_count_reg [TABLE_DEPTH];
    logic [CNT_W-1:0]   entry_count_reg;
    logic [PAGE_W-1:0]  end_page_reg;

    logic               action_reg;
    logic [PAGE_W-1:0]  page_reg;
    logic [COUNT_W-1:0] count_reg;

    logic [TABLE_DEPTH-1:0] exact_vec_reg;
    logic [TABLE_DEPTH-1:0] gt_vec_reg;
    logic [TABLE_DEPTH-1:0] exact_vec_next;
    logic [TABLE_DEPTH-1:0] gt_vec_next;

    logic               hit_reg;
    logic               exact_hit_reg;
    logic [IDX_W-1:0]   k_reg;
    logic [PAGE_W-1:0]  sel_start_reg;
    logic [COUNT_W-1:0] sel_count_reg;
    logic [IDX_W-1:0]   k_next;
    logic [IDX_W-1:0]   ex_idx;
    logic [IDX_W-1:0]   gt_idx;

    logic               res_valid_reg;
    logic [PAGE_W-1:0]  res_page_reg;
    source_t            res_source_reg;
    logic               res_dropped_reg;

    logic               table_full;
    logic [IDX_W-1:0]   wr_idx;
    logic [PAGE_W-1:0]  reuse_page;
    logic               take_fresh;

    assign table_full = (entry_count_reg == CNT_W'(TABLE_DEPTH));
    assign wr_idx     = entry_count_reg[IDX_W-1:0];
    assign reuse_page = hit_reg ? sel_start_reg : '0;
    // page zero is never handed out from the table
    assign take_fresh = (reuse_page == '0);

    always_comb
    begin
        for (int j = 0; j < TABLE_DEPTH; j++)
        begin
            exact_vec_next[j] = (CNT_W'(j) < entry_count_reg) &&
                                (tbl_count_reg[j] == count_reg);
            gt_vec_next[j]    = (CNT_W'(j) < entry_count_reg) &&
                                (tbl_count_reg[j] > count_reg);
        end
    end

    // lowest-indexed match wins
    always_comb
    begin
        ex_idx = '0;
        gt_idx = '0;
        for (int j = TABLE_DEPTH - 1; j >= 0; j--)
        begin
            if (exact_vec_reg[j])
                ex_idx = IDX_W'(j);
            if (gt_vec_reg[j])
                gt_idx = IDX_W'(j);
        end
        k_next = (|exact_vec_reg) ? ex_idx : gt_idx;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            action_reg <= action;
            page_reg   <= free_page;
            count_reg  <= page_count;
        end
        if (cmd.compare)
        begin
            exact_vec_reg <= exact_vec_next;
            gt_vec_reg    <= gt_vec_next;
        end
        if (cmd.select)
        begin
            hit_reg       <= (|exact_vec_reg) || (|gt_vec_reg);
            exact_hit_reg <= |exact_vec_reg;
            k_reg         <= k_next;
            sel_start_reg <= tbl_start_reg[k_next];
            sel_count_reg <= tbl_count_reg[k_next];
        end
        if (cmd.update)
        begin
            res_dropped_reg <= (action_reg == ACT_FREE) && table_full;
            if (action_reg == ACT_FREE)
            begin
                res_page_reg    <= '0;
                res_source_reg  <= SRC_FREE;
            end
            else if (take_fresh)
            begin
                res_page_reg   <= end_page_reg;
                res_source_reg <= SRC_FRESH;
            end
            else
            begin
                res_page_reg   <= reuse_page;
                res_source_reg <= exact_hit_reg ? SRC_EXACT : SRC_SPLIT;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            if (action_reg == ACT_FREE)
            begin
                if (!table_full)
                begin
                    tbl_start_reg[wr_idx] <= page_reg;
                    tbl_count_reg[wr_idx] <= count_reg;
                end
            end
            else if (hit_reg)
            begin
                if (exact_hit_reg)
                begin
                    // close the gap left by the removed entry
                    for (int j = 0; j < TABLE_DEPTH - 1; j++)
                    begin
                        if (IDX_W'(j) >= k_reg)
                        begin
                            tbl_start_reg[j] <= tbl_start_reg[j+1];
                            tbl_count_reg[j] <= tbl_count_reg[j+1];
                        end
                    end
                end
                else
                begin
                    tbl_start_reg[k_reg] <= sel_start_reg + PAGE_W'(count_reg);
                    tbl_count_reg[k_reg] <= sel_count_reg - count_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            end_page_reg    <= END_PAGE_RESET;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            res_valid_reg <= cmd.update;
            if (cfg_we)
                end_page_reg <= cfg_data;
            else if (cmd.update && action_reg == ACT_ALLOC && take_fresh)
                end_page_reg <= end_page_reg + PAGE_W'(count_reg);
            if (cmd.update)
            begin
                if (action_reg == ACT_FREE && !table_full)
                    entry_count_reg <= entry_count_reg + CNT_W'(1);
                else if (action_reg == ACT_ALLOC && hit_reg && exact_hit_reg)
                    entry_count_reg <= entry_count_reg - CNT_W'(1);
            end
        end
    end

    assign res_valid   = res_valid_reg;
    assign res_page    = res_page_reg;
    assign res_source  = res_source_reg;
    assign res_dropped = res_dropped_reg;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entry_count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count above table depth");

    a_exact_removes: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && action_reg == ACT_ALLOC && hit_reg && exact_hit_reg)
        |=> entry_count_reg == $past(entry_count_reg) - CNT_W'(1))
        else $error("exact reuse did not remove an entry");

    a_full_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.update && action_reg == ACT_FREE && table_full)
        |=> res_valid && res_dropped && entry_count_reg == CNT_W'(TABLE_DEPTH))
        else $error("free on full table not dropped");
`endif

endmodule

FILE: design/free_page_extent_allocator.sv
`timescale 1ns / 1ps
// Flow: start is accepted in idle; done pulses once the compare, select and update
//   states have run. A new transaction is taken only back in idle, an order
//   set by the sequential compare/priority-select/table-update path.
// Reset (rst_n, async low): table empty, end pointer at page 1; table contents
//   are not cleared. Results are a one-cycle done strobe; the receiver cannot stall.

module free_page_extent_allocator
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            action,
    input  logic [fpea_pkg::PAGE_W-1:0]     free_page,
    input  logic [fpea_pkg::COUNT_W-1:0]    page_count,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fpea_pkg::PAGE_W-1:0]     cfg_data,
    output logic                            done,
    output logic [fpea_pkg::PAGE_W-1:0]     page_number_res,
    output logic [1:0]                      source,
    output logic                            dropped
);
    import fpea_pkg::*;

    dp_cmd_t cmd;
    source_t res_source;

    assign cfg_ready = 1'b1;

    fpea_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    fpea_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .action      (action),
        .free_page   (free_page),
        .page_count  (page_count),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .res_valid   (done),
        .res_page    (page_number_res),
        .res_source  (res_source),
        .res_dropped (dropped)
    );

    assign source = res_source;

endmodule
